// ===== hw/rtl/vsim_pkg.sv =====
package vsim_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LIN_W      = 21;

   localparam logic [7:0] OP_CLI   = 8'hfa;
   localparam logic [7:0] OP_STI   = 8'hfb;
   localparam logic [7:0] OP_PUSHF = 8'h9c;
   localparam logic [7:0] OP_POPF  = 8'h9d;
   localparam logic [7:0] OP_INTN  = 8'hcd;
   localparam logic [7:0] OP_IRET  = 8'hcf;

   localparam logic CSR_AREA_PRESENT = 1'b0;

   typedef enum logic [1:0] {
      ST_RESUMED      = 2'd0,
      ST_NOT_EMULATED = 2'd1,
      ST_IRQ_DUE      = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]       num_writes;
      logic [LIN_W-1:0] addr0;
      logic [LIN_W-1:0] addr1;
      logic [LIN_W-1:0] addr2;
      logic [15:0]      data0;
      logic [15:0]      data1;
      logic [15:0]      data2;
      logic [15:0]      cs;
      logic [15:0]      ip;
      logic [15:0]      sp;
      logic [15:0]      flags;
      logic             vif;
      status_type       status;
   } job_type;

   function automatic logic [LIN_W-1:0] lin_addr(logic [15:0] seg, logic [15:0] off);
      return {1'b0, seg, 4'b0000} + {5'b00000, off};
   endfunction

   function automatic logic [15:0] popped_flags(logic [15:0] w);
      return {w[15:14], 2'b00, w[11:10], 1'b1, w[8:0]};
   endfunction

endpackage

// ===== hw/rtl/vsim_req_if.sv =====
interface vsim_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode;
   logic [7:0]  vector_number;
   logic [15:0] code_segment;
   logic [15:0] instr_pointer;
   logic [15:0] stack_segment;
   logic [15:0] stack_pointer;
   logic [15:0] flags_word;
   logic [15:0] stack_word0;
   logic [15:0] stack_word1;
   logic [15:0] stack_word2;
   logic [31:0] vector_entry;
   logic        irq_waiting;

   modport source (
      output valid, opcode, vector_number, code_segment, instr_pointer, stack_segment,
             stack_pointer, flags_word, stack_word0, stack_word1, stack_word2,
             vector_entry, irq_waiting,
      input  ready
   );
   modport sink (
      input  valid, opcode, vector_number, code_segment, instr_pointer, stack_segment,
             stack_pointer, flags_word, stack_word0, stack_word1, stack_word2,
             vector_entry, irq_waiting,
      output ready
   );
endinterface

// ===== hw/rtl/vsim_rsp_if.sv =====
interface vsim_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_write;
   logic [20:0] write_addr;
   logic [15:0] write_data;
   logic [15:0] new_cs;
   logic [15:0] new_ip;
   logic [15:0] new_sp;
   logic [15:0] new_flags;
   logic        virtual_if_out;
   logic [1:0]  status;
   logic        last;

   modport source (
      output valid, is_write, write_addr, write_data, new_cs, new_ip, new_sp, new_flags,
             virtual_if_out, status, last,
      input  ready
   );
   modport sink (
      input  valid, is_write, write_addr, write_data, new_cs, new_ip, new_sp, new_flags,
             virtual_if_out, status, last,
      output ready
   );
endinterface

// ===== hw/rtl/vsim_front.sv =====
module vsim_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             area_present,
   input  logic             queue_full,
   output logic             push,
   output vsim_pkg::job_type job,
   vsim_req_if.sink         req
);
   import vsim_pkg::*;

   logic        vif_ff;
   logic        vif_in;
   logic        emulated;
   logic        vif_new;
   logic [15:0] image;
   logic [15:0] sp_m2;
   logic [15:0] sp_m4;
   logic [15:0] sp_m6;
   logic [15:0] ip_p1;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      image = {req.flags_word[15:14], 2'b11, req.flags_word[11:10], vif_ff,
               req.flags_word[8:0]};
      sp_m2 = req.stack_pointer - 16'd2;
      sp_m4 = req.stack_pointer - 16'd4;
      sp_m6 = req.stack_pointer - 16'd6;
      ip_p1 = req.instr_pointer + 16'd1;

      job.num_writes = 2'd0;
      job.addr0      = lin_addr(req.stack_segment, sp_m2);
      job.addr1      = lin_addr(req.stack_segment, sp_m4);
      job.addr2      = lin_addr(req.stack_segment, sp_m6);
      job.data0      = image;
      job.data1      = req.code_segment;
      job.data2      = req.instr_pointer + 16'd2;
      job.cs         = req.code_segment;
      job.ip         = req.instr_pointer;
      job.sp         = req.stack_pointer;
      job.flags      = req.flags_word;
      emulated       = area_present;
      vif_new        = vif_ff;

      if (area_present) begin
         case (req.opcode)
            OP_CLI: begin
               vif_new = 1'b0;
               job.ip  = ip_p1;
            end
            OP_STI: begin
               vif_new = 1'b1;
               job.ip  = ip_p1;
            end
            OP_PUSHF: begin
               job.num_writes = 2'd1;
               job.sp         = sp_m2;
               job.ip         = ip_p1;
            end
            OP_POPF: begin
               job.flags = popped_flags(req.stack_word0);
               vif_new   = req.stack_word0[9];
               job.sp    = req.stack_pointer + 16'd2;
               job.ip    = ip_p1;
            end
            OP_INTN: begin
               job.num_writes = 2'd3;
               job.sp         = sp_m6;
               vif_new        = 1'b0;
               job.flags      = {req.flags_word[15:9], 1'b0, req.flags_word[7:0]};
               job.cs         = req.vector_entry[31:16];
               job.ip         = req.vector_entry[15:0];
            end
            OP_IRET: begin
               job.ip    = req.stack_word0;
               job.cs    = req.stack_word1;
               job.flags = popped_flags(req.stack_word2);
               vif_new   = req.stack_word2[9];
               job.sp    = req.stack_pointer + 16'd6;
            end
            default: begin
               emulated = 1'b0;
            end
         endcase
      end

      if (!emulated) begin
         job.num_writes = 2'd0;
         job.cs         = req.code_segment;
         job.ip         = req.instr_pointer;
         job.sp         = req.stack_pointer;
         job.flags      = req.flags_word;
         vif_new        = vif_ff;
         job.status     = ST_NOT_EMULATED;
      end else if (!vif_ff && vif_new && req.irq_waiting) begin
         job.status = ST_IRQ_DUE;
      end else begin
         job.status = ST_RESUMED;
      end
      job.vif = vif_new;
      vif_in  = push ? vif_new : vif_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vif_ff <= 1'b0;
      end else begin
         vif_ff <= vif_in;
      end
   end
endmodule

// ===== hw/rtl/vsim_queue.sv =====
module vsim_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vsim_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output vsim_pkg::job_type head
);
   import vsim_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type           mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = count_ff == FULL_CNT;
   assign empty   = count_ff == '0;
   assign head    = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== hw/rtl/vsim_back.sv =====
module vsim_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  vsim_pkg::job_type head,
   output logic              pop,
   vsim_rsp_if.source        rsp
);
   import vsim_pkg::*;

   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic             is_write_ff, is_write_in;
   logic [LIN_W-1:0] addr_ff, addr_in;
   logic [15:0]      data_ff, data_in;
   logic [15:0]      cs_ff, cs_in;
   logic [15:0]      ip_ff, ip_in;
   logic [15:0]      sp_ff, sp_in;
   logic [15:0]      flags_ff, flags_in;
   logic             vif_ff, vif_in;
   logic [1:0]       status_ff, status_in;
   logic             last_ff, last_in;
   logic             load;

   always_comb begin
      load        = !valid_ff || rsp.ready;
      pop         = 1'b0;
      valid_in    = valid_ff;
      idx_in      = idx_ff;
      is_write_in = is_write_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      cs_in       = cs_ff;
      ip_in       = ip_ff;
      sp_in       = sp_ff;
      flags_in    = flags_ff;
      vif_in      = vif_ff;
      status_in   = status_ff;
      last_in     = last_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (idx_ff < head.num_writes) begin
               is_write_in = 1'b1;
               case (idx_ff)
                  2'd0: begin
                     addr_in = head.addr0;
                     data_in = head.data0;
                  end
                  2'd1: begin
                     addr_in = head.addr1;
                     data_in = head.data1;
                  end
                  default: begin
                     addr_in = head.addr2;
                     data_in = head.data2;
                  end
               endcase
               cs_in     = '0;
               ip_in     = '0;
               sp_in     = '0;
               flags_in  = '0;
               vif_in    = 1'b0;
               status_in = ST_RESUMED;
               last_in   = 1'b0;
               idx_in    = idx_ff + 2'd1;
            end else begin
               is_write_in = 1'b0;
               addr_in     = '0;
               data_in     = '0;
               cs_in       = head.cs;
               ip_in       = head.ip;
               sp_in       = head.sp;
               flags_in    = head.flags;
               vif_in      = head.vif;
               status_in   = head.status;
               last_in     = 1'b1;
               idx_in      = 2'd0;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      is_write_ff <= is_write_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      cs_ff       <= cs_in;
      ip_ff       <= ip_in;
      sp_ff       <= sp_in;
      flags_ff    <= flags_in;
      vif_ff      <= vif_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.is_write       = is_write_ff;
   assign rsp.write_addr     = addr_ff;
   assign rsp.write_data     = data_ff;
   assign rsp.new_cs         = cs_ff;
   assign rsp.new_ip         = ip_ff;
   assign rsp.new_sp         = sp_ff;
   assign rsp.new_flags      = flags_ff;
   assign rsp.virtual_if_out = vif_ff;
   assign rsp.status         = status_ff;
   assign rsp.last           = last_ff;
endmodule

// ===== hw/rtl/vm86_sensitive_instruction_monitor.sv =====
// Virtual-8086 monitor for trapped CLI, STI, PUSHF, POPF, INT n and IRET. A request is
// decoded against the kept virtual interrupt-enable bit in the cycle it is accepted and
// lands in a QUEUE_DEPTH-entry queue; the emitter drains the queue one result per cycle
// while rsp ready is high; a request yields one result (CLI, STI, POPF, IRET, not
// emulated), two (PUSHF) or four (INT n), and requests are accepted every cycle while the
// queue has room. Stack pushes come out first in push order, then the final result with
// last set. Register area_present sits at byte address 0 and resets to 0, which makes
// every request come back not emulated.
module vm86_sensitive_instruction_monitor #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   vsim_req_if.sink                          req_bus,
   vsim_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vsim_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vsim_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vsim_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import vsim_pkg::*;

   logic    area_ff, area_in;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type job;
   job_type head;
   logic    sel_area;

   assign csr_pready = 1'b1;
   assign sel_area   = csr_paddr[CSR_ADDR_W-1] == CSR_AREA_PRESENT;

   always_comb begin
      area_in = area_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_area) begin
         area_in = csr_pwdata[0];
      end
      csr_prdata = sel_area ? {{(CSR_DATA_W-1){1'b0}}, area_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff <= 1'b0;
      end else begin
         area_ff <= area_in;
      end
   end

   vsim_front u_front (
      .clock        (clock),
      .reset        (reset),
      .area_present (area_ff),
      .queue_full   (full),
      .push         (push),
      .job          (job),
      .req          (req_bus)
   );

   vsim_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   vsim_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );
endmodule

// ===== hw/rtl/vsim_checker.sv =====
module vsim_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_write,
   input logic [20:0] rsp_write_addr,
   input logic [15:0] rsp_write_data,
   input logic [15:0] rsp_new_sp,
   input logic        rsp_virtual_if_out,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);
   import vsim_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last) && $stable(rsp_write_addr))
      else $error("response dropped or changed while stalled");

   a_write_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_write |-> !rsp_last && rsp_new_sp == 16'd0
         && !rsp_virtual_if_out && rsp_status == ST_RESUMED)
      else $error("write response carries register fields");

   a_final_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_write |-> rsp_last && rsp_write_addr == 21'd0
         && rsp_write_data == 16'd0)
      else $error("final response malformed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_RESUMED || rsp_status == ST_NOT_EMULATED
         || rsp_status == ST_IRQ_DUE)
      else $error("illegal status code");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind vm86_sensitive_instruction_monitor vsim_checker u_vsim_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_is_write       (rsp_bus.is_write),
   .rsp_write_addr     (rsp_bus.write_addr),
   .rsp_write_data     (rsp_bus.write_data),
   .rsp_new_sp         (rsp_bus.new_sp),
   .rsp_virtual_if_out (rsp_bus.virtual_if_out),
   .rsp_status         (rsp_bus.status),
   .rsp_last           (rsp_bus.last)
);

// ===== sim/vm86_sensitive_instruction_monitor_test.sv =====
module vm86_sensitive_instruction_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vsim_pkg::*;

   localparam logic [15:0] TRAP_MASK = 16'h0100;
   localparam logic [15:0] IE_MASK = 16'h0200;
   localparam logic [15:0] IOPL_MASK = 16'h3000;
   localparam logic [CSR_ADDR_W-1:0] AREA_ADDR = CSR_ADDR_W'(4 * CSR_AREA_PRESENT);
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  vector;
      logic [15:0] cs;
      logic [15:0] ip;
      logic [15:0] ss;
      logic [15:0] sp;
      logic [15:0] flags;
      logic [15:0] w0;
      logic [15:0] w1;
      logic [15:0] w2;
      logic [31:0] vec_entry;
      logic        irq;
   } trap_req_t;

   typedef struct packed {
      logic             is_write;
      logic [LIN_W-1:0] addr;
      logic [15:0]      data;
      logic [15:0]      cs;
      logic [15:0]      ip;
      logic [15:0]      sp;
      logic [15:0]      flags;
      logic             vif;
      status_type       status;
      logic             last;
   } trap_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   vsim_req_if req_bus();
   vsim_rsp_if rsp_bus();

   vm86_sensitive_instruction_monitor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   trap_req_t    trap_queue[$];
   trap_result_t result_queue[$];
   trap_req_t    next_trap;
   trap_req_t    accepted;
   trap_result_t want;

   logic area_on = 1'b0;
   logic guest_vif = 1'b0;
   int   idle_pct = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   quiet_cycles = 0;
   int   errors = 0;
   int   n_requests = 0;
   int   n_pushes = 0;
   int   n_finals = 0;
   int   n_irq_due = 0;
   int   n_not_emulated = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
   endtask

   function automatic void record_push(logic [15:0] ss, logic [15:0] sp, logic [15:0] data);
      trap_result_t r;
      r = '0;
      r.is_write = 1'b1;
      r.addr = ({5'b00000, ss} << 4) + {5'b00000, sp};
      r.data = data;
      r.status = ST_RESUMED;
      result_queue.push_back(r);
   endfunction

   function automatic void emulate_trap(trap_req_t t);
      logic [15:0] cs, ip, sp, fl, image;
      logic vif;
      logic done;
      trap_result_t r;
      cs = t.cs;
      ip = t.ip;
      sp = t.sp;
      fl = t.flags;
      vif = guest_vif;
      image = (t.flags & ~IE_MASK) | (guest_vif ? IE_MASK : 16'h0000) | IOPL_MASK;
      done = area_on;
      if (area_on) begin
         case (t.opcode)
            OP_CLI: begin
               vif = 1'b0;
               ip = ip + 16'd1;
            end
            OP_STI: begin
               vif = 1'b1;
               ip = ip + 16'd1;
            end
            OP_PUSHF: begin
               sp = sp - 16'd2;
               record_push(t.ss, sp, image);
               ip = ip + 16'd1;
            end
            OP_POPF: begin
               fl = (t.w0 & ~IOPL_MASK) | IE_MASK;
               vif = t.w0[9];
               sp = sp + 16'd2;
               ip = ip + 16'd1;
            end
            OP_INTN: begin
               sp = sp - 16'd2;
               record_push(t.ss, sp, image);
               sp = sp - 16'd2;
               record_push(t.ss, sp, t.cs);
               sp = sp - 16'd2;
               record_push(t.ss, sp, t.ip + 16'd2);
               vif = 1'b0;
               fl = fl & ~TRAP_MASK;
               cs = t.vec_entry[31:16];
               ip = t.vec_entry[15:0];
            end
            OP_IRET: begin
               ip = t.w0;
               cs = t.w1;
               fl = (t.w2 & ~IOPL_MASK) | IE_MASK;
               vif = t.w2[9];
               sp = sp + 16'd6;
            end
            default: done = 1'b0;
         endcase
      end
      r = '0;
      r.cs = cs;
      r.ip = ip;
      r.sp = sp;
      r.flags = fl;
      r.last = 1'b1;
      if (!done) begin
         vif = guest_vif;
         r.status = ST_NOT_EMULATED;
      end else if (!guest_vif && vif && t.irq) begin
         r.status = ST_IRQ_DUE;
      end else begin
         r.status = ST_RESUMED;
      end
      r.vif = vif;
      guest_vif = vif;
      result_queue.push_back(r);
   endfunction

   function automatic logic [7:0] pick_opcode();
      case ($urandom_range(0, 9))
         0: return OP_CLI;
         1, 2: return OP_STI;
         3: return OP_PUSHF;
         4: return OP_POPF;
         5, 6: return OP_INTN;
         7: return OP_IRET;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic trap_req_t random_trap(logic [7:0] op);
      trap_req_t t;
      t.opcode = op;
      t.vector = 8'($urandom);
      t.cs = 16'($urandom);
      t.ip = 16'($urandom);
      t.ss = 16'($urandom);
      t.sp = 16'($urandom);
      t.flags = 16'($urandom);
      t.w0 = 16'($urandom);
      t.w1 = 16'($urandom);
      t.w2 = 16'($urandom);
      t.vec_entry = $urandom;
      t.irq = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0: t.sp = 16'h0000;
         1: t.sp = 16'hffff;
         2: t.sp = 16'h0002;
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0) t.ss = 16'hffff;
      if ($urandom_range(0, 7) == 0) t.ip = 16'hffff;
      return t;
   endfunction

   task automatic queue_random(input int count);
      trap_req_t t, r;
      int added;
      added = 0;
      while (added < count) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               t = random_trap(OP_INTN);
               r = random_trap(OP_IRET);
               r.cs = t.vec_entry[31:16];
               r.ip = t.vec_entry[15:0];
               r.ss = t.ss;
               r.sp = t.sp - 16'd6;
               r.w0 = t.ip + 16'd2;
               r.w1 = t.cs;
               r.w2 = t.flags | IOPL_MASK;
               trap_queue.push_back(t);
               trap_queue.push_back(r);
               added += 2;
            end
            2: begin
               t = random_trap(OP_PUSHF);
               r = random_trap(OP_POPF);
               r.ss = t.ss;
               r.sp = t.sp - 16'd2;
               r.ip = t.ip + 16'd1;
               r.w0 = t.flags | IOPL_MASK;
               trap_queue.push_back(t);
               trap_queue.push_back(r);
               added += 2;
            end
            default: begin
               trap_queue.push_back(random_trap(pick_opcode()));
               added++;
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (trap_queue.size() != 0 || req_bus.valid || result_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_area_present(input logic on);
      logic [CSR_DATA_W-1:0] readback;
      readback = '0;
      for (int pass = 0; pass < 2; pass++) begin
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= (pass == 0);
         csr_paddr <= AREA_ADDR;
         csr_pwdata <= {{(CSR_DATA_W-1){1'b0}}, on};
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         readback = csr_prdata;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end
      if (readback[0] !== on)
         report_mismatch($sformatf("area_present reads %h after writing %b", readback, on));
      area_on = on;
   endtask

   task automatic run_phase(input logic on, input int count, input int pct);
      set_area_present(on);
      idle_pct = pct;
      queue_random(count);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (trap_queue.size() != 0) begin
            next_trap = trap_queue.pop_front();
            req_bus.opcode <= next_trap.opcode;
            req_bus.vector_number <= next_trap.vector;
            req_bus.code_segment <= next_trap.cs;
            req_bus.instr_pointer <= next_trap.ip;
            req_bus.stack_segment <= next_trap.ss;
            req_bus.stack_pointer <= next_trap.sp;
            req_bus.flags_word <= next_trap.flags;
            req_bus.stack_word0 <= next_trap.w0;
            req_bus.stack_word1 <= next_trap.w1;
            req_bus.stack_word2 <= next_trap.w2;
            req_bus.vector_entry <= next_trap.vec_entry;
            req_bus.irq_waiting <= next_trap.irq;
            req_bus.valid <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) send_gap <= $urandom_range(1, 6);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         accepted.opcode = req_bus.opcode;
         accepted.vector = req_bus.vector_number;
         accepted.cs = req_bus.code_segment;
         accepted.ip = req_bus.instr_pointer;
         accepted.ss = req_bus.stack_segment;
         accepted.sp = req_bus.stack_pointer;
         accepted.flags = req_bus.flags_word;
         accepted.w0 = req_bus.stack_word0;
         accepted.w1 = req_bus.stack_word1;
         accepted.w2 = req_bus.stack_word2;
         accepted.vec_entry = req_bus.vector_entry;
         accepted.irq = req_bus.irq_waiting;
         emulate_trap(accepted);
         n_requests++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (result_queue.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
         end else begin
            want = result_queue.pop_front();
            check_field("is_write", 32'(rsp_bus.is_write), 32'(want.is_write));
            check_field("write_addr", 32'(rsp_bus.write_addr), 32'(want.addr));
            check_field("write_data", 32'(rsp_bus.write_data), 32'(want.data));
            check_field("new_cs", 32'(rsp_bus.new_cs), 32'(want.cs));
            check_field("new_ip", 32'(rsp_bus.new_ip), 32'(want.ip));
            check_field("new_sp", 32'(rsp_bus.new_sp), 32'(want.sp));
            check_field("new_flags", 32'(rsp_bus.new_flags), 32'(want.flags));
            check_field("virtual_if_out", 32'(rsp_bus.virtual_if_out), 32'(want.vif));
            check_field("status", 32'(rsp_bus.status), 32'(want.status));
            check_field("last", 32'(rsp_bus.last), 32'(want.last));
         end
         if (rsp_bus.is_write) n_pushes++;
         else n_finals++;
         if (!rsp_bus.is_write && rsp_bus.status == ST_IRQ_DUE) n_irq_due++;
         if (!rsp_bus.is_write && rsp_bus.status == ST_NOT_EMULATED) n_not_emulated++;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: %0d cycles without a transfer", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      trap_req_t t;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.vector_number = '0;
      req_bus.code_segment = '0;
      req_bus.instr_pointer = '0;
      req_bus.stack_segment = '0;
      req_bus.stack_pointer = '0;
      req_bus.flags_word = '0;
      req_bus.stack_word0 = '0;
      req_bus.stack_word1 = '0;
      req_bus.stack_word2 = '0;
      req_bus.vector_entry = '0;
      req_bus.irq_waiting = 1'b0;
      rsp_bus.ready = 1'b0;
      idle_pct = 20;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // area absent out of reset: everything comes back not emulated
      queue_random(4);
      wait_drained();

      set_area_present(1'b1);
      t = random_trap(OP_CLI);
      t.ip = 16'hffff;
      t.flags = 16'hffff;
      trap_queue.push_back(t);
      t = random_trap(OP_STI);
      t.flags = 16'h0000;
      t.irq = 1'b1;
      trap_queue.push_back(t);
      t = random_trap(OP_STI);
      t.irq = 1'b1;
      trap_queue.push_back(t);
      t = random_trap(OP_PUSHF);
      t.ss = 16'hffff;
      t.sp = 16'h0000;
      trap_queue.push_back(t);
      t = random_trap(OP_POPF);
      t.sp = 16'hffff;
      t.w0 = 16'h0000;
      trap_queue.push_back(t);
      t = random_trap(OP_POPF);
      t.w0 = 16'hffff;
      t.irq = 1'b1;
      trap_queue.push_back(t);
      t = random_trap(OP_PUSHF);
      t.ss = 16'hffff;
      t.sp = 16'hffff;
      t.flags = 16'h0000;
      trap_queue.push_back(t);
      t = random_trap(OP_INTN);
      t.vector = 8'h00;
      t.vec_entry = 32'h0000_0000;
      t.ip = 16'hfffe;
      t.sp = 16'h0002;
      t.cs = 16'hffff;
      t.flags = 16'hffff;
      trap_queue.push_back(t);
      t = random_trap(OP_INTN);
      t.vector = 8'hff;
      t.vec_entry = 32'hffff_ffff;
      t.ss = 16'h0000;
      t.sp = 16'h0000;
      t.flags = 16'h0000;
      trap_queue.push_back(t);
      t = random_trap(OP_IRET);
      t.sp = 16'hfffe;
      t.w0 = 16'hffff;
      t.w1 = 16'hffff;
      t.w2 = IE_MASK;
      t.irq = 1'b1;
      trap_queue.push_back(t);
      t = random_trap(OP_IRET);
      t.sp = 16'hfffa;
      t.w0 = 16'h0000;
      t.w1 = 16'h0000;
      t.w2 = 16'hfdff;
      trap_queue.push_back(t);
      t = random_trap(8'h00);
      trap_queue.push_back(t);
      t = random_trap(8'hff);
      trap_queue.push_back(t);
      t = random_trap(OP_STI);
      t.irq = 1'b0;
      trap_queue.push_back(t);
      t = random_trap(OP_CLI);
      t.irq = 1'b1;
      trap_queue.push_back(t);
      t = random_trap(OP_INTN - 8'd1);
      trap_queue.push_back(t);
      t = random_trap(OP_IRET - 8'd1);
      trap_queue.push_back(t);
      t = random_trap(OP_POPF);
      t.w0 = IE_MASK;
      t.irq = 1'b0;
      trap_queue.push_back(t);
      wait_drained();

      run_phase(1'b0, 15, 30);
      run_phase(1'b1, 70, 40);
      run_phase(1'b1, 50, $urandom_range(0, 1) ? 15 : 0);
      run_phase(1'b1, 45, 0);

      $display("Covered %0d trapped requests: %0d stack pushes, %0d final results",
               n_requests, n_pushes, n_finals);
      $display("Interrupt-due resumes %0d, not emulated %0d, area toggled both ways, %0d errors",
               n_irq_due, n_not_emulated, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
